// ===== hdl/sppq_pkg.sv =====
// ----------------------------------------------------------------------------
// sppq_pkg
// Shared types and codes of the stable priority packet queue.
// ----------------------------------------------------------------------------
package sppq_pkg;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_CHECK = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_e;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the request fields
    logic execute;  // apply the request to the queue
  } cmd_t;

  localparam int unsigned BYTES_W = 20;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned LEN_W   = 16;

endpackage

// ===== hdl/stable_priority_packet_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_packet_queue
// Priority-ordered descriptor queue with push, pop and ID check requests.
// ----------------------------------------------------------------------------
//   Channel   Handshake               Payload
//   in        in_valid_i / in_ready_o req_type, priority, tag, bytes, query ID
//   out       out_valid_o/out_ready_i status, IDs, head entry, totals
//
// Each request is captured, then executed in a step in which every slot of
// the shift-register array compares and shifts in parallel, and then its
// result is shown until the consumer takes it.
// A stalled output holds the block; no new request is taken meanwhile.
// Reset clears the fill state and ID counter; entry contents need none.
module stable_priority_packet_queue #(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned PRIORITY_BITS = 4,
  parameter int unsigned TAG_BITS      = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               req_type_i,
  input  logic [PRIORITY_BITS-1:0] priority_req_i,
  input  logic [TAG_BITS-1:0]      payload_tag_i,
  input  logic [15:0]              payload_bytes_i,
  input  logic [31:0]              query_id_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic [31:0]              assigned_id_o,
  output logic                     found_o,
  output logic                     head_valid_o,
  output logic [31:0]              head_id_o,
  output logic [PRIORITY_BITS-1:0] head_priority_o,
  output logic [TAG_BITS-1:0]      head_tag_o,
  output logic [15:0]              head_bytes_o,
  output logic [19:0]              queued_bytes_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] entry_count_o
);
  import sppq_pkg::*;

  cmd_t cmd;

  sppq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd)
  );

  sppq_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH), .PRIORITY_BITS(PRIORITY_BITS), .TAG_BITS(TAG_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .req_type_i, .priority_req_i, .payload_tag_i, .payload_bytes_i, .query_id_i,
    .status_o, .assigned_id_o, .found_o, .head_valid_o, .head_id_o,
    .head_priority_o, .head_tag_o, .head_bytes_o, .queued_bytes_o, .entry_count_o
  );

endmodule

// ===== hdl/sppq_ctrl.sv =====
// ----------------------------------------------------------------------------
// sppq_ctrl
// Request sequencer: capture, execute, then hold the result until taken.
// ----------------------------------------------------------------------------
module sppq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sppq_pkg::cmd_t cmd_o
);
  import sppq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== hdl/sppq_datapath.sv =====
// ----------------------------------------------------------------------------
// sppq_datapath
// Shift-register entry array with parallel priority and ID compares.
// ----------------------------------------------------------------------------
module sppq_datapath #(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned PRIORITY_BITS = 4,
  parameter int unsigned TAG_BITS      = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sppq_pkg::cmd_t           cmd_i,
  input  logic [1:0]               req_type_i,
  input  logic [PRIORITY_BITS-1:0] priority_req_i,
  input  logic [TAG_BITS-1:0]      payload_tag_i,
  input  logic [15:0]              payload_bytes_i,
  input  logic [31:0]              query_id_i,
  output logic [1:0]               status_o,
  output logic [31:0]              assigned_id_o,
  output logic                     found_o,
  output logic                     head_valid_o,
  output logic [31:0]              head_id_o,
  output logic [PRIORITY_BITS-1:0] head_priority_o,
  output logic [TAG_BITS-1:0]      head_tag_o,
  output logic [15:0]              head_bytes_o,
  output logic [19:0]              queued_bytes_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] entry_count_o
);
  import sppq_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

  logic [ID_W-1:0]          id_q   [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] pri_q  [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]      tag_q  [QUEUE_DEPTH];
  logic [LEN_W-1:0]         len_q  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   occ_q;   // thermometer of filled slots
  logic [CW-1:0]            cnt_q;
  logic [ID_W-1:0]          last_id_q;
  logic [BYTES_W-1:0]       bytes_q;

  logic [1:0]               req_q;
  logic [PRIORITY_BITS-1:0] rpri_q;
  logic [TAG_BITS-1:0]      rtag_q;
  logic [LEN_W-1:0]         rlen_q;
  logic [ID_W-1:0]          rqid_q;

  logic [1:0]      status_q;
  logic [ID_W-1:0] assigned_q;
  logic            found_q;

  // A slot takes the new entry when it is the first that is empty or of lower priority.
  logic [QUEUE_DEPTH-1:0] lower, after_ins, hit;
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      lower[i] = occ_q[i] && (rpri_q != '0) && (pri_q[i] < rpri_q);
      hit[i]   = occ_q[i] && (id_q[i] == rqid_q);
    end
    // after_ins[i]: slot i lies at or past the insertion point.
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      after_ins[i] = !occ_q[i] || lower[i];
      if (i > 0) after_ins[i] = after_ins[i] || after_ins[i-1];
    end
  end

  wire do_push = cmd_i.execute && (req_q == REQ_PUSH) && (cnt_q != FULL);
  wire do_pop  = cmd_i.execute && (req_q == REQ_POP) && occ_q[0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_type_i;
      rpri_q <= priority_req_i;
      rtag_q <= payload_tag_i;
      rlen_q <= payload_bytes_i;
      rqid_q <= query_id_i;
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (do_push && after_ins[i]) begin
        if (i == 0 || !after_ins[(i == 0) ? 0 : i-1]) begin
          id_q[i]  <= last_id_q + 32'd1;
          pri_q[i] <= rpri_q;
          tag_q[i] <= rtag_q;
          len_q[i] <= rlen_q;
        end else begin
          id_q[i]  <= id_q[(i == 0) ? 0 : i-1];
          pri_q[i] <= pri_q[(i == 0) ? 0 : i-1];
          tag_q[i] <= tag_q[(i == 0) ? 0 : i-1];
          len_q[i] <= len_q[(i == 0) ? 0 : i-1];
        end
      end else if (do_pop && i < QUEUE_DEPTH - 1) begin
        id_q[i]  <= id_q[(i < QUEUE_DEPTH - 1) ? i+1 : i];
        pri_q[i] <= pri_q[(i < QUEUE_DEPTH - 1) ? i+1 : i];
        tag_q[i] <= tag_q[(i < QUEUE_DEPTH - 1) ? i+1 : i];
        len_q[i] <= len_q[(i < QUEUE_DEPTH - 1) ? i+1 : i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q      <= '0;
      cnt_q      <= '0;
      last_id_q  <= '0;
      bytes_q    <= '0;
      status_q   <= ST_DONE;
      assigned_q <= '0;
      found_q    <= 1'b0;
    end else if (cmd_i.execute) begin
      status_q   <= ST_DONE;
      assigned_q <= '0;
      found_q    <= 1'b0;
      unique case (req_q)
        REQ_PUSH: begin
          if (do_push) begin
            occ_q      <= {occ_q[QUEUE_DEPTH-2:0], 1'b1};
            cnt_q      <= cnt_q + CW'(1);
            last_id_q  <= last_id_q + 32'd1;
            assigned_q <= last_id_q + 32'd1;
            bytes_q    <= bytes_q + BYTES_W'(rlen_q);
          end else begin
            status_q <= ST_FULL;
          end
        end
        REQ_POP: begin
          if (do_pop) begin
            occ_q   <= {1'b0, occ_q[QUEUE_DEPTH-1:1]};
            cnt_q   <= cnt_q - CW'(1);
            bytes_q <= bytes_q - BYTES_W'(len_q[0]);
          end else begin
            status_q <= ST_EMPTY;
          end
        end
        REQ_CHECK: found_q <= |hit;
        default: ;
      endcase
    end
  end

  assign status_o        = status_q;
  assign assigned_id_o   = assigned_q;
  assign found_o         = found_q;
  assign head_valid_o    = occ_q[0];
  assign head_id_o       = occ_q[0] ? id_q[0] : '0;
  assign head_priority_o = occ_q[0] ? pri_q[0] : '0;
  assign head_tag_o      = occ_q[0] ? tag_q[0] : '0;
  assign head_bytes_o    = occ_q[0] ? len_q[0] : '0;
  assign queued_bytes_o  = bytes_q;
  assign entry_count_o   = cnt_q;

endmodule

// ===== sim/stable_priority_packet_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_packet_queue_tb
// Self-checking bench for the priority packet queue: a local queue model
// predicts every result; directed cases, random bursts of idling on both
// channels, a long consumer hold-off under push-heavy traffic, and a final quiet stretch.
// ----------------------------------------------------------------------------
module stable_priority_packet_queue_tb;
  import sppq_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // One predicted result.
  typedef struct {
    logic [1:0]  status;
    logic [31:0] assigned_id;
    logic        found;
    logic        head_valid;
    logic [31:0] head_id;
    logic [3:0]  head_priority;
    logic [15:0] head_tag;
    logic [15:0] head_bytes;
    logic [19:0] queued_bytes;
    logic [4:0]  entry_count;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  req_type_i = REQ_NONE;
  logic [3:0]  priority_req_i = '0;
  logic [15:0] payload_tag_i = '0;
  logic [15:0] payload_bytes_i = '0;
  logic [31:0] query_id_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] assigned_id_o;
  logic        found_o;
  logic        head_valid_o;
  logic [31:0] head_id_o;
  logic [3:0]  head_priority_o;
  logic [15:0] head_tag_o;
  logic [15:0] head_bytes_o;
  logic [19:0] queued_bytes_o;
  logic [4:0]  entry_count_o;

  stable_priority_packet_queue dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Local copy of the queue, head at index 0.
  logic [31:0] mdl_id[$];
  logic [3:0]  mdl_pri[$];
  logic [15:0] mdl_tag[$];
  logic [15:0] mdl_len[$];
  logic [31:0] mdl_last_id = '0;
  logic [19:0] mdl_bytes = '0;
  result_t     pending_results[$];

  int  fail_count = 0;
  bit  send_idle = 1'b1;   // random gaps on the request side
  bit  recv_idle = 1'b1;   // random stalls on the result side
  bit  recv_hold = 1'b0;   // long consumer hold-off
  int  hold_cycles = 0;
  longint cycle_count = 0;

  // Applies one request to the local queue and queues its expected result.
  function automatic void predict_queue_result(logic [1:0] kind, logic [3:0] pri,
                                               logic [15:0] tag, logic [15:0] len,
                                               logic [31:0] qid);
    result_t r;
    int pos;
    r = '{default: '0};
    case (kind)
      REQ_PUSH: begin
        if (mdl_id.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          mdl_last_id = mdl_last_id + 32'd1;
          r.assigned_id = mdl_last_id;
          mdl_bytes = mdl_bytes + 20'(len);
          pos = mdl_id.size();
          if (pri != 0) begin
            for (int i = 0; i < mdl_id.size(); i++) begin
              if (mdl_pri[i] < pri) begin
                pos = i;
                break;
              end
            end
          end
          mdl_id.insert(pos, mdl_last_id);
          mdl_pri.insert(pos, pri);
          mdl_tag.insert(pos, tag);
          mdl_len.insert(pos, len);
        end
      end
      REQ_POP: begin
        if (mdl_id.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          mdl_bytes = mdl_bytes - 20'(mdl_len[0]);
          mdl_id.delete(0);
          mdl_pri.delete(0);
          mdl_tag.delete(0);
          mdl_len.delete(0);
        end
      end
      REQ_CHECK: begin
        foreach (mdl_id[i]) if (mdl_id[i] == qid) r.found = 1'b1;
      end
      default: ;
    endcase
    if (mdl_id.size() > 0) begin
      r.head_valid = 1'b1;
      r.head_id = mdl_id[0];
      r.head_priority = mdl_pri[0];
      r.head_tag = mdl_tag[0];
      r.head_bytes = mdl_len[0];
    end
    r.queued_bytes = mdl_bytes;
    r.entry_count = 5'(mdl_id.size());
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Sends one request and waits until the block takes it. Valid stays high
  // after the accepting edge; the next call either replaces the payload or
  // drops valid for an idle gap.
  task automatic send_request(logic [1:0] kind, logic [3:0] pri, logic [15:0] tag,
                              logic [15:0] len, logic [31:0] qid);
    int gap;
    if (send_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    priority_req_i <= pri;
    payload_tag_i <= tag;
    payload_bytes_i <= len;
    query_id_i <= qid;
    do @(posedge clk_i); while (!in_ready_o);
    predict_queue_result(kind, pri, tag, len, qid);
  endtask

  // Random request with a kind mix weighted by the caller.
  task automatic send_random(int push_weight, int pop_weight);
    int sel;
    logic [1:0] kind;
    logic [31:0] qid;
    sel = $urandom_range(0, 99);
    if (sel < push_weight) kind = REQ_PUSH;
    else if (sel < push_weight + pop_weight) kind = REQ_POP;
    else if (sel < 97) kind = REQ_CHECK;
    else kind = REQ_NONE;
    // Checks mostly ask for IDs that are near the live range.
    if (mdl_id.size() > 0 && $urandom_range(0, 1))
      qid = mdl_id[$urandom_range(0, mdl_id.size() - 1)];
    else if ($urandom_range(0, 1)) qid = mdl_last_id - 32'($urandom_range(0, 40));
    else qid = $urandom();
    send_request(kind, 4'($urandom_range(0, 15)), 16'($urandom()), 16'($urandom()), qid);
  endtask

  // Result side: stall pattern.
  always @(posedge clk_i) begin
    if (recv_hold) begin
      out_ready_i <= 1'b0;
    end else if (recv_idle && hold_cycles == 0 && $urandom_range(0, 5) == 0) begin
      hold_cycles = $urandom_range(1, 15);
      out_ready_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_ready_i <= (hold_cycles == 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Result side: compare every accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result, status %0d", status_o);
        fail_count++;
      end else begin
        e = pending_results[0];
        pending_results.delete(0);
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); fail_count++;
        end
        if (assigned_id_o !== e.assigned_id) begin
          $error("assigned_id exp %0h got %0h", e.assigned_id, assigned_id_o); fail_count++;
        end
        if (found_o !== e.found) begin
          $error("found exp %0d got %0d", e.found, found_o); fail_count++;
        end
        if (head_valid_o !== e.head_valid) begin
          $error("head_valid exp %0d got %0d", e.head_valid, head_valid_o); fail_count++;
        end
        if (head_id_o !== e.head_id) begin
          $error("head_id exp %0h got %0h", e.head_id, head_id_o); fail_count++;
        end
        if (head_priority_o !== e.head_priority) begin
          $error("head_priority exp %0d got %0d", e.head_priority, head_priority_o);
          fail_count++;
        end
        if (head_tag_o !== e.head_tag) begin
          $error("head_tag exp %0h got %0h", e.head_tag, head_tag_o); fail_count++;
        end
        if (head_bytes_o !== e.head_bytes) begin
          $error("head_bytes exp %0d got %0d", e.head_bytes, head_bytes_o); fail_count++;
        end
        if (queued_bytes_o !== e.queued_bytes) begin
          $error("queued_bytes exp %0d got %0d", e.queued_bytes, queued_bytes_o);
          fail_count++;
        end
        if (entry_count_o !== e.entry_count) begin
          $error("entry_count exp %0d got %0d", e.entry_count, entry_count_o); fail_count++;
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Directed: empty pop, check on empty, push extremes, equal priorities,
  // priority zero to the back, fill to full and reject, reserved kind.
  task automatic test_directed();
    send_request(REQ_POP, 4'd0, 16'd0, 16'd0, 32'd0);
    send_request(REQ_CHECK, 4'd0, 16'd0, 16'd0, 32'd1);
    send_request(REQ_PUSH, 4'd0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(REQ_PUSH, 4'd15, 16'h0000, 16'h0000, 32'd0);
    send_request(REQ_PUSH, 4'd15, 16'h5A5A, 16'd100, 32'd0);
    send_request(REQ_PUSH, 4'd7, 16'hA5A5, 16'd1, 32'd0);
    send_request(REQ_PUSH, 4'd0, 16'h1234, 16'd2, 32'd0);
    send_request(REQ_CHECK, 4'd0, 16'd0, 16'd0, 32'd3);
    send_request(REQ_CHECK, 4'd0, 16'd0, 16'd0, 32'hFFFF_FFFF);
    send_request(REQ_NONE, 4'd15, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 12; i++)
      send_request(REQ_PUSH, 4'($urandom_range(0, 15)), 16'($urandom()), 16'hFFFF, 32'd0);
    send_request(REQ_PUSH, 4'd15, 16'hFFFF, 16'hFFFF, 32'd0);
    while (mdl_id.size() > 0) send_request(REQ_POP, 4'd0, 16'd0, 16'd0, 32'd0);
    send_request(REQ_POP, 4'd0, 16'd0, 16'd0, 32'd0);
  endtask

  // Random traffic with varying push/pop balance so the queue sweeps its depth.
  task automatic test_random_mix(int count);
    for (int i = 0; i < count; i++) begin
      case ((i / 100) % 3)
        0: send_random(60, 20);
        1: send_random(25, 55);
        default: send_random(40, 40);
      endcase
    end
  endtask

  // Consumer holds off for a long stretch while push-heavy requests are offered.
  task automatic test_output_stall();
    recv_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 40; i++) send_random(80, 10);
    join
  endtask

  // Random traffic with no idling on either side, requests back to back.
  task automatic test_quiet_tail(int count);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    test_random_mix(count);
  endtask

  initial begin
    int waited;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_mix(1000);
    test_output_stall();
    test_random_mix(300);
    test_quiet_tail(250);
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_results.size() > 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sppq_pkg.sv
hdl/sppq_ctrl.sv
hdl/sppq_datapath.sv
hdl/stable_priority_packet_queue.sv
sim/stable_priority_packet_queue_tb.sv
